FILE: rtl/matrix4_row_multiply_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix row multiply unit
// Shared helpers that wrap a concurrent assertion with clock and reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX4_ROW_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX4_ROW_MULTIPLY_UNIT_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define M4RM_ASSERT_CR(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Assertion on the standard clk_i and rst_ni of the enclosing scope.
`define M4RM_ASSERT(name, prop, msg) \
  `M4RM_ASSERT_CR(name, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/m4rm_pkg.sv
// ----------------------------------------------------------------------------
// Matrix row multiply package
// Shared sizes, payload types and command codes of the row multiply unit.
// ----------------------------------------------------------------------------
package m4rm_pkg;

  localparam int unsigned Dim         = 4;
  localparam int unsigned ElemW       = 32;
  localparam int unsigned RowW        = 2;
  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned ProdW       = 2 * ElemW;
  // Wide enough for the sum of Dim full products, whatever the fraction width.
  localparam int unsigned SumW        = ProdW + $clog2(Dim);

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [SumW-1:0]  sum_t;

  localparam elem_t ElemMax = {1'b0, {(ElemW-1){1'b1}}};
  localparam elem_t ElemMin = {1'b1, {(ElemW-1){1'b0}}};

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_MUL  = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [RowW-1:0] row_index;
    elem_t           elem0;
    elem_t           elem1;
    elem_t           elem2;
    elem_t           elem3;
  } in_item_t;

  typedef struct packed {
    logic [RowW-1:0] out_row;
    elem_t           res0;
    elem_t           res1;
    elem_t           res2;
    elem_t           res3;
    logic            saturated;
  } out_item_t;

  // Token that travels along the cell chain.
  typedef struct packed {
    cmd_e                cmd;
    logic [RowW-1:0]     row;
    elem_t [Dim-1:0]     elem;
    sum_t  [Dim-1:0]     psum;
  } chain_tok_t;

endpackage

FILE: rtl/matrix4_row_multiply_unit.sv
// ----------------------------------------------------------------------------
// Matrix row multiply unit
// Streams rows of A through a chain of cells holding B and returns A times B.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                               Direction  Moves
//   input    in_valid_i / in_ready_o / in_data_i   in         one row of B or A
//   output   out_valid_o / out_ready_i / out_data_o out       one result row
//
// One transfer is taken every cycle while the output side keeps up.
// A multiply row passes two register stages in each of the Dim cells and then
// the output register, where its result is presented. Load rows give no
// result and leave the chain silently. Reset clears every valid bit; the
// stored matrix stays undefined until loaded. A stalled output fills the
// chain's empty stages first, so input transfers stop only once every stage
// holds an item.
//
module matrix4_row_multiply_unit import m4rm_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // Chain links: link 0 is the input, link Dim leaves the last cell.
  logic       link_valid [Dim+1];
  logic       link_ready [Dim+1];
  chain_tok_t link_tok   [Dim+1];

  logic       out_valid_q;
  out_item_t  out_data_q;
  logic       out_load;
  elem_t      sat_val [Dim];
  logic [Dim-1:0] sat_clip;

  // The incoming row enters the chain with zero running sums.
  always_comb begin
    link_tok[0].cmd     = in_data_i.cmd;
    link_tok[0].row     = in_data_i.row_index;
    link_tok[0].elem[0] = in_data_i.elem0;
    link_tok[0].elem[1] = in_data_i.elem1;
    link_tok[0].elem[2] = in_data_i.elem2;
    link_tok[0].elem[3] = in_data_i.elem3;
    link_tok[0].psum    = '0;
  end

  assign link_valid[0] = in_valid_i;
  assign in_ready_o    = link_ready[0];

  // Cell k owns row k of B and adds floor(a[k] * B[k][c] / 2^FRAC_BITS)
  // to each running column sum as the token passes through.
  for (genvar g = 0; g < Dim; g++) begin : g_cell
    m4rm_cell #(
      .FRAC_BITS(FRAC_BITS),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .up_valid_i(link_valid[g]),
      .up_ready_o(link_ready[g]),
      .up_tok_i  (link_tok[g]),
      .dn_valid_o(link_valid[g+1]),
      .dn_ready_i(link_ready[g+1]),
      .dn_tok_o  (link_tok[g+1])
    );
  end

  // Load tokens are dropped at the end of the chain and never wait for the
  // output register; multiply tokens wait until it is free or being emptied.
  assign link_ready[Dim] = (link_tok[Dim].cmd == CMD_LOAD) || !out_valid_q || out_ready_i;
  assign out_load = link_valid[Dim] && link_ready[Dim] && (link_tok[Dim].cmd == CMD_MUL);

  // Clip each full-width sum to the signed element range.
  always_comb begin
    for (int c = 0; c < Dim; c++) begin
      if ((&link_tok[Dim].psum[c][SumW-1:ElemW-1]) ||
          !(|link_tok[Dim].psum[c][SumW-1:ElemW-1])) begin
        sat_val[c]  = link_tok[Dim].psum[c][ElemW-1:0];
        sat_clip[c] = 1'b0;
      end else begin
        sat_val[c]  = link_tok[Dim].psum[c][SumW-1] ? ElemMin : ElemMax;
        sat_clip[c] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.out_row   <= link_tok[Dim].row;
      out_data_q.res0      <= sat_val[0];
      out_data_q.res1      <= sat_val[1];
      out_data_q.res2      <= sat_val[2];
      out_data_q.res3      <= sat_val[3];
      out_data_q.saturated <= |sat_clip;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/m4rm_cell.sv
// ----------------------------------------------------------------------------
// Matrix row multiply cell
// Holds one row of the right matrix and adds its share to the running sums.
// ----------------------------------------------------------------------------
module m4rm_cell import m4rm_pkg::*; #(
  parameter int unsigned FRAC_BITS = FracBitsDef,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       up_valid_i,
  output logic       up_ready_o,
  input  chain_tok_t up_tok_i,
  output logic       dn_valid_o,
  input  logic       dn_ready_i,
  output chain_tok_t dn_tok_o
);

  localparam int unsigned ShW = ProdW - FRAC_BITS;
  localparam logic [RowW-1:0] MyRow = RowW'(CELL_IDX);

  elem_t [Dim-1:0]         brow_q;
  logic                    m_valid_q;
  chain_tok_t              m_tok_q;
  logic signed [ProdW-1:0] prod_q [Dim];
  logic signed [ShW-1:0]   prod_sh [Dim];
  logic                    s_valid_q;
  chain_tok_t              s_tok_q;
  logic                    m_ready;
  logic                    s_ready;
  logic                    up_fire;
  logic                    m_fire;

  assign s_ready    = !s_valid_q || dn_ready_i;
  assign m_ready    = !m_valid_q || s_ready;
  assign up_ready_o = m_ready;
  assign up_fire    = up_valid_i && m_ready;
  assign m_fire     = m_valid_q && s_ready;
  assign dn_valid_o = s_valid_q;
  assign dn_tok_o   = s_tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid_q <= up_valid_i;
      end
      if (s_ready) begin
        s_valid_q <= m_valid_q;
      end
    end
  end

  // A load for this row is stored as it enters, so later multiplies see it
  // and earlier ones have already taken their products.
  always_ff @(posedge clk_i) begin
    if (up_fire && (up_tok_i.cmd == CMD_LOAD) && (up_tok_i.row == MyRow)) begin
      brow_q <= up_tok_i.elem;
    end
  end

  always_ff @(posedge clk_i) begin
    if (up_fire) begin
      m_tok_q <= up_tok_i;
      for (int c = 0; c < Dim; c++) begin
        prod_q[c] <= $signed(up_tok_i.elem[MyRow]) * $signed(brow_q[c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < Dim; c++) begin
      prod_sh[c] = ShW'(prod_q[c] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_fire) begin
      s_tok_q.cmd  <= m_tok_q.cmd;
      s_tok_q.row  <= m_tok_q.row;
      s_tok_q.elem <= m_tok_q.elem;
      for (int c = 0; c < Dim; c++) begin
        s_tok_q.psum[c] <= $signed(m_tok_q.psum[c]) + SumW'(prod_sh[c]);
      end
    end
  end

endmodule

FILE: rtl/m4rm_checker.sv
// ----------------------------------------------------------------------------
// Matrix row multiply port checker
// Watches the unit's ports for stall handling and flag consistency.
// ----------------------------------------------------------------------------
`include "matrix4_row_multiply_unit_defines.svh"

module m4rm_checker import m4rm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  logic in_stall;
  logic out_stall;
  logic sat_extreme;

  assign in_stall    = in_valid_i && !in_ready_o;
  assign out_stall   = out_valid_o && !out_ready_i;
  assign sat_extreme = (out_data_o.res0 == ElemMax) || (out_data_o.res0 == ElemMin) ||
                       (out_data_o.res1 == ElemMax) || (out_data_o.res1 == ElemMin) ||
                       (out_data_o.res2 == ElemMax) || (out_data_o.res2 == ElemMin) ||
                       (out_data_o.res3 == ElemMax) || (out_data_o.res3 == ElemMin);

  // A result that is not taken holds its value.
  `M4RM_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_data_o), "result changed while stalled")

  // An offered row that is not taken stays on offer unchanged.
  `M4RM_ASSERT(a_in_hold, in_stall |=> in_valid_i && $stable(in_data_i), "input changed while stalled")

  // The input side only stalls when the output side is stalled.
  `M4RM_ASSERT(a_stall_cause, !in_ready_o |-> out_stall, "input stalled without output back-pressure")

  // A clipped row carries at least one extreme value.
  `M4RM_ASSERT(a_sat_value, out_valid_o && out_data_o.saturated |-> sat_extreme, "saturation flag without a clipped value")

endmodule

bind matrix4_row_multiply_unit m4rm_checker u_m4rm_checker (.*);

FILE: tb/tb_matrix4_row_multiply_unit.sv
// ----------------------------------------------------------------------------
// Matrix row multiply unit testbench
// Streams rows of B and A through the unit and checks every result row
// against a Q16.16 prediction of A times B. A directed opening comes first,
// then random matrix jobs, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_matrix4_row_multiply_unit;
  import m4rm_pkg::*;

  // Timing of the run.
  localparam int unsigned FracBits    = FracBitsDef;
  localparam int unsigned RandomItems = 1700;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldStart   = 600;
  localparam int unsigned HoldLen     = 80;
  localparam int unsigned DrainCycles = 2 * Dim + 8;

  // Handy Q16.16 values.
  localparam elem_t QOne      = 32'sh0001_0000;
  localparam int    SmallSpan = 32'h0004_0000;

  // Output-side stall patterns.
  typedef enum logic [1:0] {
    RX_FREE,
    RX_HALF,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data   = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_data_o;

  // Rows waiting to be offered, the predicted result rows still owed by the
  // unit, and the prediction's own copy of the right-hand matrix.
  in_item_t  rows_to_send [$];
  out_item_t expected_rows [$];
  elem_t     b_matrix [Dim][Dim];

  int unsigned n_to_send;
  int unsigned n_accepted;
  int unsigned n_errors;

  // Sender burst state and receiver pattern state.
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rx_cycles;
  int unsigned mode_left;
  int unsigned hold_left;
  rx_mode_e    rx_mode;

  matrix4_row_multiply_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Takes one accepted row into the prediction. A load row replaces a row of
  // B and owes nothing. A multiply row owes one result row: each column is
  // the sum of the products shifted down by the fraction width (an
  // arithmetic shift, so rounding is towards minus infinity), clipped to the
  // 32-bit signed range.
  function automatic void absorb_row(in_item_t it);
    elem_t                   a [Dim];
    elem_t                   res [Dim];
    logic signed [ProdW-1:0] pa;
    logic signed [ProdW-1:0] pb;
    logic signed [ProdW-1:0] prod;
    sum_t                    acc;
    logic                    clipped;
    out_item_t               row_out;
    a = '{it.elem0, it.elem1, it.elem2, it.elem3};
    if (it.cmd == CMD_LOAD) begin
      for (int k = 0; k < Dim; k++) b_matrix[it.row_index][k] = a[k];
      return;
    end
    clipped = 1'b0;
    for (int c = 0; c < Dim; c++) begin
      acc = '0;
      for (int k = 0; k < Dim; k++) begin
        pa   = a[k];
        pb   = b_matrix[k][c];
        prod = pa * pb;
        acc  = acc + (prod >>> FracBits);
      end
      if (acc > sum_t'(ElemMax)) begin
        res[c]  = ElemMax;
        clipped = 1'b1;
      end else if (acc < sum_t'(ElemMin)) begin
        res[c]  = ElemMin;
        clipped = 1'b1;
      end else begin
        res[c] = acc[ElemW-1:0];
      end
    end
    row_out.out_row   = it.row_index;
    row_out.res0      = res[0];
    row_out.res1      = res[1];
    row_out.res2      = res[2];
    row_out.res3      = res[3];
    row_out.saturated = clipped;
    expected_rows.push_back(row_out);
  endfunction

  function automatic void queue_row(cmd_e c, logic [RowW-1:0] r,
                                    elem_t e0, elem_t e1, elem_t e2, elem_t e3);
    in_item_t it;
    it.cmd       = c;
    it.row_index = r;
    it.elem0     = e0;
    it.elem1     = e1;
    it.elem2     = e2;
    it.elem3     = e3;
    rows_to_send.push_back(it);
  endfunction

  // Element values: mostly full-range noise or small values that keep the
  // sums clear of the clip, with the odd extreme and whole number mixed in.
  function automatic elem_t rand_elem();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom();
      4, 5, 6, 7: v = int'($urandom_range(0, 2 * SmallSpan)) - SmallSpan;
      8: begin
        case ($urandom_range(0, 4))
          0:       v = ElemMax;
          1:       v = ElemMin;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      default: v = (int'($urandom_range(0, 16)) - 8) * QOne;
    endcase
    return elem_t'(v);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_errors++;
    end
  endfunction

  // Sender. Offers queued rows in bursts of random length separated by
  // random gaps. Once valid is raised it is held, with the same row, until
  // the transfer completes; every transfer is handed to the prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
      n_accepted = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        absorb_row(in_data);
        n_accepted++;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0 || rows_to_send.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= rows_to_send.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Receiver. Picks a new random stall pattern whenever the current one runs
  // out. Once in the run it holds off for a long stretch so that the chain
  // fills and the unit has to stop taking input transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_cycles = 0;
      mode_left = 0;
      hold_left = 0;
      rx_mode   = RX_FREE;
    end else begin
      rx_cycles++;
      if (rx_cycles == HoldStart) hold_left = HoldLen;
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ~out_ready;
        endcase
      end
    end
  end

  // Monitor. Each result transfer is matched against the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: result row with none expected, expected nothing, actual %h",
                 $time, out_data_o);
        n_errors++;
      end else begin
        want = expected_rows.pop_front();
        check_field("out_row", want.out_row, out_data_o.out_row);
        check_field("res0", want.res0, out_data_o.res0);
        check_field("res1", want.res1, out_data_o.res1);
        check_field("res2", want.res2, out_data_o.res2);
        check_field("res3", want.res3, out_data_o.res3);
        check_field("saturated", want.saturated, out_data_o.saturated);
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on either side for too
  // long once reset is released.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("matrix4_row_multiply_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned start;
    int unsigned step;
    int unsigned n_mul;
    n_errors = 0;

    // Directed opening. B is loaded in full before any multiply, so no
    // unwritten entry is ever read. Identity first: the results must give
    // back the A row exactly, extremes included.
    for (int r = 0; r < Dim; r++) begin
      queue_row(CMD_LOAD, 2'(r), (r == 0) ? QOne : elem_t'(0), (r == 1) ? QOne : elem_t'(0),
                (r == 2) ? QOne : elem_t'(0), (r == 3) ? QOne : elem_t'(0));
    end
    queue_row(CMD_MUL, 2'd0, ElemMax, ElemMin, elem_t'(0), elem_t'(-1));
    queue_row(CMD_MUL, 2'd1, elem_t'(1), elem_t'(-1), QOne, -QOne);
    queue_row(CMD_MUL, 2'd2, elem_t'(0), elem_t'(0), elem_t'(0), elem_t'(0));
    queue_row(CMD_MUL, 2'd3, rand_elem(), rand_elem(), rand_elem(), rand_elem());
    // Smallest step everywhere: a product of minus one step shifts down to
    // minus one, not to zero, so the rounding towards minus infinity shows.
    for (int r = 0; r < Dim; r++) begin
      queue_row(CMD_LOAD, 2'(r), elem_t'(1), elem_t'(1), elem_t'(1), elem_t'(1));
    end
    queue_row(CMD_MUL, 2'd0, elem_t'(-1), elem_t'(-1), elem_t'(-1), elem_t'(-1));
    queue_row(CMD_MUL, 2'd1, elem_t'(1), elem_t'(1), elem_t'(1), elem_t'(1));
    queue_row(CMD_MUL, 2'd2, ElemMin, ElemMin, ElemMin, ElemMin);
    // Largest magnitudes: clipping at the top and at the bottom.
    for (int r = 0; r < Dim; r++) begin
      queue_row(CMD_LOAD, 2'(r), ElemMax, ElemMax, ElemMax, ElemMax);
    end
    queue_row(CMD_MUL, 2'd3, ElemMax, ElemMax, ElemMax, ElemMax);
    queue_row(CMD_MUL, 2'd2, ElemMin, ElemMin, ElemMin, ElemMin);
    queue_row(CMD_MUL, 2'd1, ElemMax, ElemMin, ElemMax, ElemMin);
    // Most negative times most negative gives the largest product of all.
    queue_row(CMD_LOAD, 2'd0, ElemMin, ElemMin, ElemMin, ElemMin);
    queue_row(CMD_MUL, 2'd0, ElemMin, elem_t'(0), elem_t'(0), elem_t'(0));

    // Random part. Half are matrix jobs: sometimes a fresh B, loaded row by
    // row in a rotated order, forwards or backwards, then a run of A rows. The
    // rest are loose rows of either kind.
    n_to_send = rows_to_send.size() + RandomItems;
    while (rows_to_send.size() < n_to_send) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          if ($urandom_range(0, 1) == 1) begin
            start = $urandom_range(0, Dim - 1);
            step  = ($urandom_range(0, 1) == 1) ? 1 : 3;
            for (int i = 0; i < Dim; i++) begin
              queue_row(CMD_LOAD, 2'((start + i * step) % Dim),
                        rand_elem(), rand_elem(), rand_elem(), rand_elem());
            end
          end
          n_mul = $urandom_range(1, 8);
          for (int i = 0; i < n_mul; i++) begin
            queue_row(CMD_MUL, 2'($urandom_range(0, Dim - 1)),
                      rand_elem(), rand_elem(), rand_elem(), rand_elem());
          end
        end
        default: begin
          queue_row(($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_MUL,
                    2'($urandom_range(0, Dim - 1)),
                    rand_elem(), rand_elem(), rand_elem(), rand_elem());
        end
      endcase
    end
    n_to_send = rows_to_send.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Polling on the falling edge keeps clear of the clocked processes.
    while (n_accepted < n_to_send) @(negedge clk_i);
    while (expected_rows.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (n_errors == 0 && expected_rows.size() == 0) begin
      $display("matrix4_row_multiply_unit regression: pass");
    end else begin
      $display("matrix4_row_multiply_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/m4rm_pkg.sv
rtl/m4rm_cell.sv
rtl/matrix4_row_multiply_unit.sv
rtl/m4rm_checker.sv
tb/tb_matrix4_row_multiply_unit.sv
